// ===== rtl/core/kwm_pkg.sv =====
// kwm_pkg: shared types and constants for the k-way record merger
// no dependencies
`default_nettype none
package kwm_pkg;
  localparam int unsigned Sources = 16;
  localparam int unsigned Bounds  = 64;
  localparam int unsigned SrcW    = 4;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned QDepth  = 2;

  typedef enum logic [2:0] {
    FnSupply  = 3'd0,
    FnPop     = 3'd1,
    FnBatch   = 3'd2,
    FnBound   = 3'd3,
    FnRestart = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    StRecord = 3'd0,
    StRefill = 3'd1,
    StBound  = 3'd2,
    StFull   = 3'd3,
    StEmpty  = 3'd4
  } status_e;

  localparam logic CfgRefill = 1'b0;
  localparam logic CfgBcount = 1'b1;

  // one classified command passed from the front to the back
  typedef struct packed {
    logic [2:0]       func;
    logic [SrcW-1:0]  source;
    logic [63:0]      hdr_hi;
    logic [15:0]      hdr_lo;
    logic             part_last;
    logic [31:0]      limit;
    logic [SlotW-1:0] slot;
    logic [63:0]      bval;
  } cmd_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [63:0]     hdr_hi;
    logic [15:0]     hdr_lo;
    logic [SrcW-1:0] source;
    logic            want_next;
  } res_t;
endpackage
`default_nettype wire

// ===== rtl/core/kwm_front.sv =====
// kwm_front: accepts input transactions, drops unused codes, queues commands
// depends on kwm_pkg
`default_nettype none
module kwm_front import kwm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  output logic            s_ready_o,
  input  wire cmd_t       s_cmd_i,
  output logic            q_valid_o,
  input  wire logic       q_ready_i,
  output cmd_t            q_cmd_o
);
  cmd_t       mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop, keep;

  // codes above restart carry no work and are dropped here
  always_comb begin
    keep = (s_cmd_i.func == FnSupply) || (s_cmd_i.func == FnPop) ||
           (s_cmd_i.func == FnBatch) || (s_cmd_i.func == FnBound) ||
           (s_cmd_i.func == FnRestart);
  end

  assign s_ready_o = (cnt_q != 2'(QDepth));
  assign push      = s_valid_i && s_ready_o && keep;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_cmd_o   = mem_q[rp_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= s_cmd_i;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("queue overflow");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
  a_empty_nopop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("pop on empty");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/kwm_back.sv =====
// kwm_back: head table, sequential minimum search, batch and boundary checks
// depends on kwm_pkg
`default_nettype none
module kwm_back import kwm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  output logic      q_ready_o,
  input  wire cmd_t q_cmd_i,
  input  wire logic refill_mode_i,
  input  wire logic [6:0] bound_count_i,
  output logic      m_valid_o,
  input  wire logic m_ready_i,
  output res_t      m_res_o
);
  localparam logic [2:0] SIdle = 3'd0, SScan = 3'd1, SRd = 3'd2,
                         SCheck = 3'd3, SOut = 3'd4;

  logic [63:0]     key_q  [Sources];
  logic [15:0]     tail_q [Sources];
  logic [Sources-1:0] valid_q, final_q;
  logic [63:0]     btab_q [Bounds];
  logic [63:0]     bnd_q;
  logic [6:0]      bptr_q;
  logic [31:0]     emit_q, limit_q;
  logic [2:0]      st_q;
  logic [SrcW:0]   scan_q;
  logic [SrcW-1:0] best_q;
  logic            found_q;
  logic [63:0]     bkey_q;
  logic [15:0]     btail_q;
  res_t            res_q;
  logic            out_q;
  logic [SrcW-1:0] si;
  logic            better, bchk;
  logic [6:0]      inuse;

  assign si        = scan_q[SrcW-1:0];
  assign q_ready_o = (st_q == SIdle) && !out_q;
  assign m_valid_o = out_q;
  assign m_res_o   = res_q;
  assign inuse     = (bound_count_i > 7'(Bounds)) ? 7'(Bounds) : bound_count_i;
  assign better    = valid_q[si] && (!found_q || key_q[si] < bkey_q ||
                     (key_q[si] == bkey_q && tail_q[si] < btail_q));
  assign bchk      = bptr_q < inuse;

  // boundary table memory, registered read
  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o && q_cmd_i.func == FnBound) begin
      btab_q[q_cmd_i.slot] <= q_cmd_i.bval;
    end
    bnd_q <= btab_q[bptr_q[SlotW-1:0]];
  end

  // head payload and search registers
  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o && q_cmd_i.func == FnSupply) begin
      key_q[q_cmd_i.source]   <= q_cmd_i.hdr_hi;
      tail_q[q_cmd_i.source]  <= q_cmd_i.hdr_lo;
      final_q[q_cmd_i.source] <= q_cmd_i.part_last;
    end
    if (st_q == SScan && better) begin
      best_q <= si; bkey_q <= key_q[si]; btail_q <= tail_q[si];
    end
  end

  // sequencer: one head compared per cycle, then checks and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; valid_q <= '0; bptr_q <= 7'd1; emit_q <= '0;
      limit_q <= '0; scan_q <= '0; found_q <= 1'b0; out_q <= 1'b0;
      res_q <= '0;
    end else begin
      if (out_q && m_ready_i) out_q <= 1'b0;
      unique case (st_q)
        SIdle: begin
          if (q_valid_i && q_ready_o) begin
            case (q_cmd_i.func)
              FnSupply:  valid_q[q_cmd_i.source] <= 1'b1;
              FnBatch:   begin limit_q <= q_cmd_i.limit; emit_q <= '0; end
              FnRestart: begin
                valid_q <= '0; bptr_q <= 7'd1; emit_q <= '0; limit_q <= '0;
              end
              FnPop: begin
                st_q <= SScan; scan_q <= '0; found_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        SScan: begin
          if (better) found_q <= 1'b1;
          scan_q <= scan_q + 1'b1;
          if (scan_q == (SrcW+1)'(Sources - 1)) st_q <= SRd;
        end
        SRd: st_q <= SCheck;
        SCheck: begin
          st_q  <= SOut;
          if (!found_q) begin
            res_q <= '{StEmpty, 64'd0, 16'd0, {SrcW{1'b0}}, 1'b0};
          end else if (emit_q >= limit_q) begin
            res_q <= '{StFull, 64'd0, 16'd0, {SrcW{1'b0}}, 1'b0};
          end else if (bchk && bkey_q >= bnd_q) begin
            res_q  <= '{StBound, 64'd0, 16'd0, {SrcW{1'b0}}, 1'b0};
            bptr_q <= bptr_q + 7'd1;
          end else begin
            valid_q[best_q] <= 1'b0;
            emit_q <= emit_q + 32'd1;
            res_q  <= '{(final_q[best_q] && refill_mode_i) ? StRefill : StRecord,
                        bkey_q, btail_q, best_q, !final_q[best_q]};
          end
        end
        SOut: begin
          out_q <= 1'b1; st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == SOut |-> !out_q) else $error("result overwritten");
  a_found_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == SCheck && found_q |-> valid_q[best_q]) else $error("stale best");
  a_ptr_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == SCheck && !(bchk) |=> bptr_q == $past(bptr_q)) else $error("ptr moved");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/kwm_cfg.sv =====
// kwm_cfg: configuration registers written through the config channel
// depends on kwm_pkg
`default_nettype none
module kwm_cfg import kwm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [0:0]  index_i,
  input  wire logic [6:0]  data_i,
  output logic             refill_mode_o,
  output logic [6:0]       bound_count_o
);
  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refill_mode_o <= 1'b0; bound_count_o <= '0;
    end else if (valid_i) begin
      if (index_i == CfgRefill) refill_mode_o <= data_i[0];
      if (index_i == CfgBcount) bound_count_o <= data_i;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/kway_record_merger.sv =====
// kway_record_merger: top level of the k-way record merger
// depends on kwm_pkg, kwm_front, kwm_back, kwm_cfg
// Usage:
//  s_axis carries commands (supply head, pop, begin batch, write boundary,
//  restart); only a pop produces a transaction on m_axis.
//  cfg channel writes refill_mode (index 0) and bound_count (index 1).
//  A front queue of two entries takes commands while the back works.
//  A pop transaction accepted on an empty queue passes the queue, the
//  minimum search over all 16 source heads, the boundary read, one check
//  and the result load before its result appears.
//  The back takes its next command the cycle after the result is taken,
//  so back to back pops do not overlap: a new pop waits for the last result.
//  Other commands complete in the back as they are accepted.
//  Reset clears all heads, sets the boundary pointer to one and zeroes the
//  batch counters; head and boundary storage stay unset until written.
//  When m_axis stalls, the result is held and the back stops; the queue
//  fills and then s_axis_tready drops.
`default_nettype none
module kway_record_merger import kwm_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // func, source, header_hi, header_lo, part_last, batch_limit, table_slot,
  // bound_value from bit 0 up
  input  wire logic [191:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status, out_header_hi, out_header_lo, out_source, want_next from bit 0 up
  output logic [87:0]       m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [6:0]   cfg_data
);
  cmd_t cmd, qcmd;
  res_t res;
  logic qv, qr, refill_mode;
  logic [6:0] bound_count;

  // unpack input fields
  assign cmd.func      = s_axis_tdata[2:0];
  assign cmd.source    = s_axis_tdata[6:3];
  assign cmd.hdr_hi    = s_axis_tdata[70:7];
  assign cmd.hdr_lo    = s_axis_tdata[86:71];
  assign cmd.part_last = s_axis_tdata[87];
  assign cmd.limit     = s_axis_tdata[119:88];
  assign cmd.slot      = s_axis_tdata[125:120];
  assign cmd.bval      = s_axis_tdata[189:126];

  assign cfg_ready = 1'b1;
  assign m_axis_tdata = {res.want_next, res.source, res.hdr_lo,
                         res.hdr_hi, res.status};

  kwm_cfg u_cfg (.clk_i, .rst_ni, .valid_i(cfg_valid), .index_i(cfg_index),
    .data_i(cfg_data), .refill_mode_o(refill_mode), .bound_count_o(bound_count));

  kwm_front u_front (.clk_i, .rst_ni, .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready), .s_cmd_i(cmd), .q_valid_o(qv), .q_ready_i(qr),
    .q_cmd_o(qcmd));

  kwm_back u_back (.clk_i, .rst_ni, .q_valid_i(qv), .q_ready_o(qr),
    .q_cmd_i(qcmd), .refill_mode_i(refill_mode), .bound_count_i(bound_count),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_res_o(res));
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking testbench for kway_record_merger
// drives commands on s_axis and config writes, checks m_axis against a local merge predictor
// depends on kwm_pkg and kway_record_merger
`default_nettype none
module tb;
  import kwm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HoldLen  = 400;
  localparam int unsigned DogLimit = 6000;
  localparam int unsigned Settle   = 40;

  logic         clk_i  = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = '0;
  logic [6:0]   cfg_data  = '0;

  kway_record_merger dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // merger state as the predictor sees it
  logic [63:0] hd_key  [Sources];
  logic [15:0] hd_tail [Sources];
  bit          hd_valid[Sources];
  bit          hd_final[Sources];
  logic [63:0] bnd_tab [Bounds];
  bit          bnd_set [Bounds];
  logic [6:0]  bnd_ptr;
  logic [31:0] pop_cnt;
  logic [31:0] pop_limit;
  bit          refill_on;
  logic [6:0]  bnd_cnt;

  // results still owed by the block, oldest first
  res_t        pending_res[$];
  int unsigned errors = 0;

  // sender and receiver idling controls
  bit          calm = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_cnt = 0;

  // stream bookkeeping for well-formed refills
  bit          owed[Sources];
  logic [63:0] last_key[Sources];

  function automatic int unsigned bounds_used();
    return (bnd_cnt > Bounds) ? Bounds : bnd_cnt;
  endfunction

  // advance the predictor by one command; returns 1 when a result is due
  function automatic bit merge_step(input cmd_t c, output res_t r);
    int best;
    best = -1;
    r = '0;
    case (c.func)
      FnSupply: begin
        hd_key[c.source]   = c.hdr_hi;
        hd_tail[c.source]  = c.hdr_lo;
        hd_final[c.source] = c.part_last;
        hd_valid[c.source] = 1'b1;
        return 1'b0;
      end
      FnBatch: begin
        pop_limit = c.limit;
        pop_cnt = '0;
        return 1'b0;
      end
      FnBound: begin
        bnd_tab[c.slot] = c.bval;
        bnd_set[c.slot] = 1'b1;
        return 1'b0;
      end
      FnRestart: begin
        foreach (hd_valid[i]) hd_valid[i] = 1'b0;
        bnd_ptr = 7'd1;
        pop_cnt = '0;
        pop_limit = '0;
        return 1'b0;
      end
      FnPop: ;
      default: return 1'b0;
    endcase
    for (int s = 0; s < Sources; s++) begin
      if (hd_valid[s] && (best < 0 || hd_key[s] < hd_key[best] ||
          (hd_key[s] == hd_key[best] && hd_tail[s] < hd_tail[best])))
        best = s;
    end
    if (best < 0) begin
      r.status = StEmpty;
      return 1'b1;
    end
    if (pop_cnt >= pop_limit) begin
      r.status = StFull;
      return 1'b1;
    end
    if (bnd_ptr < bounds_used() && hd_key[best] >= bnd_tab[bnd_ptr % Bounds]) begin
      bnd_ptr = bnd_ptr + 7'd1;
      r.status = StBound;
      return 1'b1;
    end
    hd_valid[best] = 1'b0;
    pop_cnt = pop_cnt + 1;
    r.hdr_hi = hd_key[best];
    r.hdr_lo = hd_tail[best];
    r.source = best[SrcW-1:0];
    if (!hd_final[best]) begin
      r.status = StRecord;
      r.want_next = 1'b1;
    end else begin
      r.status = refill_on ? StRefill : StRecord;
      r.want_next = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic cmd_t mk_cmd(logic [2:0] f, logic [SrcW-1:0] src, logic [63:0] hi,
                                  logic [15:0] lo, logic last, logic [31:0] lim,
                                  logic [SlotW-1:0] slot, logic [63:0] bv);
    cmd_t c;
    c.func = f; c.source = src; c.hdr_hi = hi; c.hdr_lo = lo; c.part_last = last;
    c.limit = lim; c.slot = slot; c.bval = bv;
    return c;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // send one command; valid stays high afterwards unless the next call idles
  task automatic send_cmd(input cmd_t c);
    int unsigned gap;
    if (!calm && $urandom_range(99) < 30) begin
      gap = $urandom_range(6, 1);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {2'b0, c.bval, c.slot, c.limit, c.part_last, c.hdr_lo, c.hdr_hi,
                      c.source, c.func};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // predict, queue the expectation, then drive
  task automatic issue(input cmd_t c);
    res_t r;
    if (merge_step(c, r)) begin
      pending_res.push_back(r);
      if (r.status inside {StRecord, StRefill}) begin
        owed[r.source] = r.want_next;
        last_key[r.source] = r.hdr_hi;
      end
    end
    if (c.func == FnRestart) foreach (owed[i]) owed[i] = 1'b0;
    send_cmd(c);
  endtask

  // wait until the block has drained, then let it settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    wait (pending_res.size() == 0);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_cfg(input bit rf, input logic [6:0] bc);
    cfg_index <= CfgRefill;
    cfg_data  <= {6'b0, rf};
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    refill_on = rf;
    cfg_index <= CfgBcount;
    cfg_data  <= bc;
    do @(posedge clk_i); while (!cfg_ready);
    bnd_cnt = bc;
    cfg_valid <= 1'b0;
  endtask

  // one random command, shaped mostly as well-formed sorted streams
  task automatic random_cmd(output cmd_t c, output bit counts);
    int unsigned r, pick;
    int          src;
    int unsigned idx;
    c = mk_cmd(3'($urandom), SrcW'($urandom), rnd64(), 16'($urandom), 1'($urandom),
               $urandom, SlotW'($urandom), rnd64());
    counts = 1'b1;
    r = $urandom_range(99);
    src = -1;
    if (r < 48 || r >= 92) begin
      c.func = FnPop;
      // never let a pop read a boundary slot that was never written
      idx = bnd_ptr % Bounds;
      if (bnd_ptr < bounds_used() && !bnd_set[idx]) begin
        c.func = FnBound;
        c.slot = idx[SlotW-1:0];
      end
    end else if (r < 78) begin
      c.func = FnSupply;
      pick = $urandom_range(Sources - 1);
      for (int k = 0; k < Sources; k++)
        if (src < 0 && owed[(pick + k) % Sources]) src = (pick + k) % Sources;
      if (src >= 0 && $urandom_range(9) != 0) begin
        c.source = src[SrcW-1:0];
        c.hdr_hi = last_key[src] + (($urandom_range(3) == 0) ? {32'b0, $urandom} :
                                    64'($urandom_range(50)));
        c.part_last = ($urandom_range(5) == 0);
        owed[src] = 1'b0;
      end
    end else if (r < 82) begin
      c.func = FnBatch;
      case ($urandom_range(3))
        0: c.limit = $urandom_range(8);
        1: c.limit = $urandom;
        default: c.limit = '1;
      endcase
    end else if (r < 87) begin
      c.func = FnBound;
    end else if (r < 89) begin
      c.func = FnRestart;
    end else begin
      c.func = 3'($urandom_range(7, 5));
      counts = 1'b0;
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= HoldLen;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 30);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_res.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (m_axis_tdata[2:0] != want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, m_axis_tdata[2:0]);
          errors++;
        end
        if (m_axis_tdata[66:3] != want.hdr_hi) begin
          $display("%0t: header_hi exp %h got %h", $time, want.hdr_hi, m_axis_tdata[66:3]);
          errors++;
        end
        if (m_axis_tdata[82:67] != want.hdr_lo) begin
          $display("%0t: header_lo exp %h got %h", $time, want.hdr_lo, m_axis_tdata[82:67]);
          errors++;
        end
        if (m_axis_tdata[86:83] != want.source) begin
          $display("%0t: source exp %0d got %0d", $time, want.source, m_axis_tdata[86:83]);
          errors++;
        end
        if (m_axis_tdata[87] != want.want_next) begin
          $display("%0t: want_next exp %0b got %0b", $time, want.want_next,
                   m_axis_tdata[87]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= DogLimit) begin
        $display("FAIL kway_record_merger");
        $finish;
      end
    end
  end

  typedef struct {
    bit   is_cfg;  // config row: slot[0] is refill_mode, limit[6:0] is bound_count
    bit   typed;
    cmd_t c;
    res_t want;
  } row_t;

  // main sequence
  initial begin
    row_t        rows[$];
    row_t        rw;
    cmd_t        c;
    bit          counts;
    int unsigned done;
    bit          phase_rf[6]  = '{0, 1, 0, 1, 0, 1};
    logic [6:0]  phase_bc[6]  = '{7'd64, 7'd127, 7'd0, 7'd20, 7'd1, 7'd64};

    foreach (hd_valid[i]) begin
      hd_valid[i] = 0; hd_final[i] = 0; hd_key[i] = '0; hd_tail[i] = '0;
      owed[i] = 0; last_key[i] = '0;
    end
    foreach (bnd_set[i]) begin
      bnd_set[i] = 0; bnd_tab[i] = '0;
    end
    bnd_ptr = 7'd1; pop_cnt = '0; pop_limit = '0; refill_on = 0; bnd_cnt = '0;

    // directed table
    rw = '{0, 1, mk_cmd(FnPop, 0, 0, 0, 0, 0, 0, 0), '{StEmpty, 0, 0, 0, 0}}; rows.push_back(rw);
    rw = '{0, 0, mk_cmd(FnSupply, 0, 64'h0, 16'h0, 0, 0, 0, 0), '0}; rows.push_back(rw);
    rw = '{0, 1, mk_cmd(FnPop, 0, 0, 0, 0, 0, 0, 0), '{StFull, 0, 0, 0, 0}}; rows.push_back(rw);
    rw = '{0, 0, mk_cmd(FnBatch, 0, 0, 0, 0, '1, 0, 0), '0}; rows.push_back(rw);
    rw = '{0, 0, mk_cmd(FnSupply, 15, '1, '1, 1, 0, 0, 0), '0}; rows.push_back(rw);
    rw = '{0, 1, mk_cmd(FnPop, 0, 0, 0, 0, 0, 0, 0), '{StRecord, 0, 0, 0, 1}};
    rows.push_back(rw);
    rw = '{0, 1, mk_cmd(FnPop, 0, 0, 0, 0, 0, 0, 0), '{StRecord, '1, '1, 15, 0}};
    rows.push_back(rw);
    rw = '{0, 1, mk_cmd(FnPop, 0, 0, 0, 0, 0, 0, 0), '{StEmpty, 0, 0, 0, 0}}; rows.push_back(rw);
    rw = '{0, 0, mk_cmd(FnBound, 0, 0, 0, 0, 0, 0, 64'd0), '0}; rows.push_back(rw);
    rw = '{0, 0, mk_cmd(FnBound, 0, 0, 0, 0, 0, 1, 64'd1000), '0}; rows.push_back(rw);
    rw = '{0, 0, mk_cmd(FnBound, 0, 0, 0, 0, 0, 2, 64'd5000), '0}; rows.push_back(rw);
    rw = '{0, 0, mk_cmd(FnBound, 0, 0, 0, 0, 0, 63, '1), '0}; rows.push_back(rw);
    rw = '{1, 0, mk_cmd(0, 0, 0, 0, 0, 32'd3, 6'd1, 0), '0}; rows.push_back(rw);
    rw = '{0, 0, mk_cmd(FnSupply, 3, 64'd2000, 16'd7, 1, 0, 0, 0), '0}; rows.push_back(rw);
    rw = '{0, 0, mk_cmd(FnSupply, 4, 64'd2000, 16'd3, 0, 0, 0, 0), '0}; rows.push_back(rw);
    rw = '{0, 0, mk_cmd(FnSupply, 5, 64'd2000, 16'd3, 0, 0, 0, 0), '0}; rows.push_back(rw);
    // key above boundary one: boundary status, pointer moves on
    rw = '{0, 1, mk_cmd(FnPop, 0, 0, 0, 0, 0, 0, 0), '{StBound, 0, 0, 0, 0}}; rows.push_back(rw);
    // full tie goes to the lower source, then refill on the last record
    for (int k = 0; k < 3; k++) begin
      rw = '{0, 0, mk_cmd(FnPop, 0, 0, 0, 0, 0, 0, 0), '0}; rows.push_back(rw);
    end
    rw = '{0, 0, mk_cmd(3'd5, 1, 1, 1, 1, 1, 1, 1), '0}; rows.push_back(rw);
    rw = '{0, 0, mk_cmd(3'd7, 2, 2, 2, 0, 2, 2, 2), '0}; rows.push_back(rw);
    rw = '{0, 0, mk_cmd(FnSupply, 6, 64'd10, 16'd1, 0, 0, 0, 0), '0}; rows.push_back(rw);
    rw = '{0, 0, mk_cmd(FnSupply, 6, 64'd9, 16'd2, 0, 0, 0, 0), '0}; rows.push_back(rw);
    rw = '{0, 0, mk_cmd(FnRestart, 0, 0, 0, 0, 0, 0, 0), '0}; rows.push_back(rw);
    rw = '{0, 1, mk_cmd(FnPop, 0, 0, 0, 0, 0, 0, 0), '{StEmpty, 0, 0, 0, 0}}; rows.push_back(rw);

    // reset
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      res_t r;
      if (rows[i].is_cfg) begin
        wait_idle();
        write_cfg(rows[i].c.slot[0], rows[i].c.limit[6:0]);
      end else if (rows[i].typed) begin
        void'(merge_step(rows[i].c, r));
        pending_res.push_back(rows[i].want);
        send_cmd(rows[i].c);
      end else begin
        issue(rows[i].c);
      end
    end

    // random phases over several register settings
    foreach (phase_bc[p]) begin
      wait_idle();
      write_cfg(phase_rf[p], phase_bc[p]);
      issue(mk_cmd(FnBatch, 0, 0, 0, 0, '1, 0, 0));
      for (int s = 0; s < Sources; s++)
        issue(mk_cmd(FnSupply, SrcW'(s), {$urandom_range(3), $urandom}, 16'($urandom),
                     0, 0, 0, 0));
      done = 0;
      while (done < 160) begin
        calm = (p == 2);
        if (p == 1 && done == 60) hold_req++;
        random_cmd(c, counts);
        issue(c);
        if (counts) done++;
      end
      calm = 1'b0;
    end

    // drain and report
    wait_idle();
    if (errors == 0) begin
      $display("PASS kway_record_merger");
    end else begin
      $display("FAIL kway_record_merger");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/kwm_pkg.sv
rtl/core/kwm_front.sv
rtl/core/kwm_back.sv
rtl/core/kwm_cfg.sv
rtl/core/kway_record_merger.sv
sim/tb.sv
